[rtl/bpe_pkg.sv]
// bpe_pkg: register map and fixed constants of the cubic Bezier point evaluator.
// No dependencies; imported by bpe_csr_file and bezier_point_evaluator.

package bpe_pkg;

   // configuration port
   localparam int CSR_INDEX_BITS = 4;
   localparam int NUM_REGS       = 8;
   localparam int REG_SEL_BITS   = 3;

   // register map
   localparam int REG_POINT0_X = 0;
   localparam int REG_POINT0_Y = 1;
   localparam int REG_POINT1_X = 2;
   localparam int REG_POINT1_Y = 3;
   localparam int REG_POINT2_X = 4;
   localparam int REG_POINT2_Y = 5;
   localparam int REG_POINT3_X = 6;
   localparam int REG_POINT3_Y = 7;

   // number of control points of a cubic curve
   localparam int NUM_POINTS = 4;

   // reset value of the last control point (1.0 in Q7.16), cut to the coordinate width
   localparam logic [63:0] POINT3_RESET = 64'd65536;

endpackage

[rtl/bpe_csr_file.sv]
// bpe_csr_file: control point registers of the Bezier evaluator, write-only port.
// Depends on bpe_pkg for the register map.

module bpe_csr_file #(
   parameter int COORD_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [bpe_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [COORD_BITS-1:0]                 csr_wr_data,
   output logic signed [COORD_BITS-1:0]          point_x [bpe_pkg::NUM_POINTS],
   output logic signed [COORD_BITS-1:0]          point_y [bpe_pkg::NUM_POINTS]
);
   import bpe_pkg::*;

   logic [COORD_BITS-1:0] regs_ff [NUM_REGS];
   logic                  index_ok;

   assign index_ok = (csr_index < CSR_INDEX_BITS'(NUM_REGS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= (i == REG_POINT3_X || i == REG_POINT3_Y) ?
                          POINT3_RESET[COORD_BITS-1:0] : '0;
         end
      end else if (csr_wr_en && index_ok) begin
         regs_ff[csr_index[REG_SEL_BITS-1:0]] <= csr_wr_data;
      end
   end

   assign point_x[0] = $signed(regs_ff[REG_POINT0_X]);
   assign point_y[0] = $signed(regs_ff[REG_POINT0_Y]);
   assign point_x[1] = $signed(regs_ff[REG_POINT1_X]);
   assign point_y[1] = $signed(regs_ff[REG_POINT1_Y]);
   assign point_x[2] = $signed(regs_ff[REG_POINT2_X]);
   assign point_y[2] = $signed(regs_ff[REG_POINT2_Y]);
   assign point_x[3] = $signed(regs_ff[REG_POINT3_X]);
   assign point_y[3] = $signed(regs_ff[REG_POINT3_Y]);

   // a write to the last point's y lands in the register on the next edge
   a_point3_y_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr_en && csr_index == CSR_INDEX_BITS'(REG_POINT3_Y))
      |=> (point_y[3] == $signed($past(csr_wr_data))))
      else $error("point3_y write not taken");

endmodule

[rtl/bpe_lerp_level.sv]
// bpe_lerp_level: one de Casteljau level, LANES independent interpolations a + ((b - a) * t >>> F).
// Three register stages (difference, product, sum) with valid bits and a ready chain. No imports.

module bpe_lerp_level #(
   parameter int COORD_BITS      = 24,
   parameter int PARAM_FRAC_BITS = 16,
   parameter int LANES           = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [PARAM_FRAC_BITS:0]      in_t,
   input  logic signed [COORD_BITS-1:0]  in_a [LANES],
   input  logic signed [COORD_BITS-1:0]  in_b [LANES],
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [PARAM_FRAC_BITS:0]      out_t,
   output logic signed [COORD_BITS-1:0]  out_p [LANES]
);
   localparam int C   = COORD_BITS;
   localparam int F   = PARAM_FRAC_BITS;
   localparam int PW  = C + F + 2;   // product width that holds |b - a| * t
   localparam int PFW = PW + 1;

   logic [2:0] valid_ff;
   logic [2:0] valid_in;
   logic [2:0] stage_ready;

   // stage 1: difference
   logic [F:0]            t1_ff;
   logic signed [C-1:0]   a1_ff [LANES];
   logic signed [C:0]     d1_ff [LANES];
   logic signed [C:0]     d1_in [LANES];
   // stage 2: product
   logic [F:0]            t2_ff;
   logic signed [C-1:0]   a2_ff [LANES];
   logic signed [PW-1:0]  prod2_ff [LANES];
   logic signed [PW:0]    prod_full [LANES];
   // stage 3: sum
   logic [F:0]            t3_ff;
   logic signed [C-1:0]   p3_ff [LANES];
   logic signed [C+1:0]   sum [LANES];
   logic signed [C-1:0]   p3_in [LANES];

   // a stage takes a new word when it is empty or its word moves on
   assign stage_ready[2] = !valid_ff[2] || out_ready;
   assign stage_ready[1] = !valid_ff[1] || stage_ready[2];
   assign stage_ready[0] = !valid_ff[0] || stage_ready[1];
   assign in_ready       = stage_ready[0];

   assign valid_in[0] = in_valid;
   assign valid_in[1] = valid_ff[0];
   assign valid_in[2] = valid_ff[1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         d1_in[l] = $signed({in_b[l][C-1], in_b[l]}) - $signed({in_a[l][C-1], in_a[l]});
         prod_full[l] = PFW'(d1_ff[l]) * PFW'($signed({1'b0, t1_ff}));
         // arithmetic shift floors toward minus infinity; result stays in the hull
         sum[l] = $signed({{2{a2_ff[l][C-1]}}, a2_ff[l]}) + $signed(prod2_ff[l][PW-1:F]);
         p3_in[l] = sum[l][C-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < 3; k++) begin
            if (stage_ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_ready[0]) begin
         t1_ff <= in_t;
         for (int l = 0; l < LANES; l++) begin
            a1_ff[l] <= in_a[l];
            d1_ff[l] <= d1_in[l];
         end
      end
      if (stage_ready[1]) begin
         t2_ff <= t1_ff;
         for (int l = 0; l < LANES; l++) begin
            a2_ff[l]    <= a1_ff[l];
            prod2_ff[l] <= prod_full[l][PW-1:0];
         end
      end
      if (stage_ready[2]) begin
         t3_ff <= t2_ff;
         for (int l = 0; l < LANES; l++) begin
            p3_ff[l] <= p3_in[l];
         end
      end
   end

   assign out_valid = valid_ff[2];
   assign out_t     = t3_ff;
   assign out_p     = p3_ff;

   // a stalled result holds its value
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && !out_ready) |=> (valid_ff[2] && $stable(p3_ff[0]) && $stable(t3_ff)))
      else $error("stalled lerp result changed");

   // a full pipe with a stalled output takes nothing in
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff == 3'b111 && !out_ready) |-> !in_ready)
      else $error("lerp level accepts while full and stalled");

endmodule

[rtl/bezier_point_evaluator.sv]
// bezier_point_evaluator: top level, cubic Bezier point per curve parameter (de Casteljau).
// Depends on bpe_pkg, bpe_csr_file and bpe_lerp_level.
//
//   channel   dir   handshake             payload (lowest bit first)
//   req_      in    req_tvalid/tready     tdata: curve_param (PARAM_FRAC_BITS+1), zero pad
//   rsp_      out   rsp_tvalid/tready     tdata: out_x, out_y (COORD_BITS each), zero pad
//   csr_      in    csr_wr_en             csr_index, csr_wr_data; no read-back
//
// An accepted req word reaches its rsp word through three de Casteljau
// levels of three stages each (difference, 25x18 multiply, shift and add).
// One word enters per cycle unless rsp stalls a full pipe; the multiplier stage of each level sets the clock.
// reset is synchronous and clears all valid bits and the control points
// (point3 to 1.0, the others to 0). A stalled rsp holds only the stages that are full;
// empty stages keep filling, so req_tready stays high while bubbles remain.

module bezier_point_evaluator #(
   parameter int COORD_BITS      = 24,
   parameter int PARAM_FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // curve_param
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((PARAM_FRAC_BITS+8)/8)*8-1:0]  req_tdata,
   // out_x, out_y
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((2*COORD_BITS+7)/8)*8-1:0]     rsp_tdata,
   input  logic                                  csr_wr_en,
   input  logic [bpe_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [COORD_BITS-1:0]                 csr_wr_data
);
   import bpe_pkg::*;

   localparam int C        = COORD_BITS;
   localparam int F        = PARAM_FRAC_BITS;
   localparam int RSP_BITS = ((2*COORD_BITS+7)/8)*8;
   localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};

   logic signed [C-1:0] point_x [NUM_POINTS];
   logic signed [C-1:0] point_y [NUM_POINTS];

   logic [F:0] t_raw;
   logic [F:0] t_clamped;

   // level 1: x lanes 0..2, y lanes 3..5
   logic signed [C-1:0] l1_a [6];
   logic signed [C-1:0] l1_b [6];
   logic signed [C-1:0] l1_p [6];
   logic                l1_valid;
   logic                l1_ready;
   logic [F:0]          l1_t;
   // level 2: x lanes 0..1, y lanes 2..3
   logic signed [C-1:0] l2_a [4];
   logic signed [C-1:0] l2_b [4];
   logic signed [C-1:0] l2_p [4];
   logic                l2_valid;
   logic                l2_ready;
   logic [F:0]          l2_t;
   // level 3: x lane 0, y lane 1
   logic signed [C-1:0] l3_a [2];
   logic signed [C-1:0] l3_b [2];
   logic signed [C-1:0] l3_p [2];
   logic [F:0]          l3_t;

   bpe_csr_file #(
      .COORD_BITS(C)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data),
      .point_x    (point_x),
      .point_y    (point_y)
   );

   // clamp t above 1.0 down to 1.0, which yields point3
   assign t_raw     = req_tdata[F:0];
   assign t_clamped = (t_raw > T_ONE) ? T_ONE : t_raw;

   // the user must keep control points stable while words are in flight (not enforced here), so read them directly
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         l1_a[i]     = point_x[i];
         l1_b[i]     = point_x[i+1];
         l1_a[i + 3] = point_y[i];
         l1_b[i + 3] = point_y[i+1];
      end
      for (int i = 0; i < 2; i++) begin
         l2_a[i]     = l1_p[i];
         l2_b[i]     = l1_p[i+1];
         l2_a[i + 2] = l1_p[i+3];
         l2_b[i + 2] = l1_p[i+4];
      end
      l3_a[0] = l2_p[0];
      l3_b[0] = l2_p[1];
      l3_a[1] = l2_p[2];
      l3_b[1] = l2_p[3];
   end

   bpe_lerp_level #(
      .COORD_BITS(C), .PARAM_FRAC_BITS(F), .LANES(6)
   ) u_level1 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_t     (t_clamped),
      .in_a     (l1_a),
      .in_b     (l1_b),
      .out_valid(l1_valid),
      .out_ready(l1_ready),
      .out_t    (l1_t),
      .out_p    (l1_p)
   );

   bpe_lerp_level #(
      .COORD_BITS(C), .PARAM_FRAC_BITS(F), .LANES(4)
   ) u_level2 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (l1_valid),
      .in_ready (l1_ready),
      .in_t     (l1_t),
      .in_a     (l2_a),
      .in_b     (l2_b),
      .out_valid(l2_valid),
      .out_ready(l2_ready),
      .out_t    (l2_t),
      .out_p    (l2_p)
   );

   // the last stage of level 3 is the output register
   bpe_lerp_level #(
      .COORD_BITS(C), .PARAM_FRAC_BITS(F), .LANES(2)
   ) u_level3 (
      .clock    (clock),
      .reset    (reset),
      .in_valid (l2_valid),
      .in_ready (l2_ready),
      .in_t     (l2_t),
      .in_a     (l3_a),
      .in_b     (l3_b),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_t    (l3_t),
      .out_p    (l3_p)
   );

   assign rsp_tdata = RSP_BITS'({l3_p[1], l3_p[0]});

   // an empty output stage lets the whole pipe advance
   a_empty_takes: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled while output is empty");

   // a taken result unblocks every stage, so input is open too
   a_drain_takes: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("req stalled while rsp is ready");

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // the parameter that travels with an output word never exceeds 1.0
   a_t_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (l3_t <= T_ONE))
      else $error("unclamped curve parameter reached the output");

endmodule
